// ===== hdl/lsp2c_pkg.sv =====
// lsp2c_pkg: shared types, constants and tables of the laser scan converter
// used by every module of the block, depends on nothing
`timescale 1ns / 1ps

package lsp2c_pkg;

  localparam int MAX_BEAMS     = 2048;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  localparam int RANGE_W = 16;
  localparam int BEAM_W  = 11;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W   = 17;
  localparam int XY_W    = 34;
  localparam int Z_W     = 32;
  localparam int IDX_W   = 5;

  localparam logic [29:0] INV_GAIN_Q30 = 30'h26DD3B6A;
  localparam logic [15:0] RANGE_MARGIN_RESET = 16'd500;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd4;

  localparam logic [Z_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic                   ok;
    logic                   last;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } beam_data_t;

  typedef struct packed {
    logic       valid;
    beam_data_t data;
  } stage_t;

endpackage

// ===== hdl/lsp2c_front.sv =====
// lsp2c_front: configuration registers, range gate, beam angle and cordic seed
// depends on lsp2c_pkg
`timescale 1ns / 1ps

module lsp2c_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [lsp2c_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsp2c_pkg::CFG_W-1:0]        cfg_data,
  input  logic                               in_valid,
  input  logic [lsp2c_pkg::RANGE_W-1:0]      in_range,
  input  logic [lsp2c_pkg::BEAM_W-1:0]       in_beam_index,
  input  logic                               in_last,
  input  logic                               down_blocked,
  output logic                               blocked,
  output lsp2c_pkg::stage_t                  stage_out
);
  import lsp2c_pkg::*;

  logic [15:0] range_min_r, range_max_r, range_margin_r, angle_start_r, angle_step_r;
  logic        valid_r;
  beam_data_t  data_r, data_nxt;

  logic signed [16:0] upper;
  logic [15:0]        angle, shifted;
  logic [13:0]        resid;
  logic [45:0]        seed_prod;
  logic [31:0]        beam_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r    <= '0;
      range_max_r    <= '0;
      range_margin_r <= RANGE_MARGIN_RESET;
      angle_start_r  <= '0;
      angle_step_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RANGE_MIN:    range_min_r    <= cfg_data;
        CFG_RANGE_MAX:    range_max_r    <= cfg_data;
        CFG_RANGE_MARGIN: range_margin_r <= cfg_data;
        CFG_ANGLE_START:  angle_start_r  <= cfg_data;
        CFG_ANGLE_STEP:   angle_step_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    upper     = $signed({1'b0, range_max_r}) - $signed({1'b0, range_margin_r});
    beam_ext  = {{(32-BEAM_W){1'b0}}, in_beam_index};
    angle     = angle_start_r + 16'({5'b0, in_beam_index} * angle_step_r);
    shifted   = angle + 16'h2000;
    resid     = {~shifted[13], shifted[12:0]};
    seed_prod = {30'b0, in_range} * {16'b0, INV_GAIN_Q30};

    data_nxt.ok   = (in_range > range_min_r) &&
                    ($signed({1'b0, in_range}) < upper) &&
                    (beam_ext < 32'(MAX_BEAMS));
    data_nxt.last = in_last;
    data_nxt.quad = shifted[15:14];
    data_nxt.x    = $signed({2'b0, seed_prod[45:14]});
    data_nxt.y    = '0;
    data_nxt.z    = $signed({{2{resid[13]}}, resid, 16'b0});
  end

  assign blocked = valid_r && down_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!blocked) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked) begin
      data_r <= data_nxt;
    end
  end

  assign stage_out.valid = valid_r;
  assign stage_out.data  = data_r;

endmodule

// ===== hdl/lsp2c_cell.sv =====
// lsp2c_cell: one cordic rotation step with its own pipeline register
// depends on lsp2c_pkg
`timescale 1ns / 1ps

module lsp2c_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lsp2c_pkg::IDX_W-1:0]   stage_idx,
  input  logic [lsp2c_pkg::Z_W-1:0]     atan,
  input  lsp2c_pkg::stage_t             stage_in,
  input  logic                          down_blocked,
  output logic                          blocked,
  output lsp2c_pkg::stage_t             stage_out
);
  import lsp2c_pkg::*;

  logic                   valid_r;
  beam_data_t             data_r, data_nxt;
  logic signed [XY_W-1:0] dx, dy;

  always_comb begin
    dx       = stage_in.data.y >>> stage_idx;
    dy       = stage_in.data.x >>> stage_idx;
    data_nxt = stage_in.data;
    if (!stage_in.data.z[Z_W-1]) begin
      data_nxt.x = stage_in.data.x - dx;
      data_nxt.y = stage_in.data.y + dy;
      data_nxt.z = stage_in.data.z - $signed(atan);
    end else begin
      data_nxt.x = stage_in.data.x + dx;
      data_nxt.y = stage_in.data.y - dy;
      data_nxt.z = stage_in.data.z + $signed(atan);
    end
  end

  assign blocked = valid_r && down_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!blocked) begin
      valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked) begin
      data_r <= data_nxt;
    end
  end

  assign stage_out.valid = valid_r;
  assign stage_out.data  = data_r;

endmodule

// ===== hdl/lsp2c_back.sv =====
// lsp2c_back: quadrant rotation, rounding to millimetres, output register
// depends on lsp2c_pkg
`timescale 1ns / 1ps

module lsp2c_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lsp2c_pkg::stage_t                    stage_in,
  output logic                                 blocked,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lsp2c_pkg::POS_W-1:0]   out_x_pos,
  output logic signed [lsp2c_pkg::POS_W-1:0]   out_y_pos,
  output logic                                 out_valid_res,
  output logic                                 out_end_of_scan
);
  import lsp2c_pkg::*;

  logic                   out_valid_r;
  logic signed [POS_W-1:0] x_r, y_r, x_nxt, y_nxt;
  logic                   res_r, eos_r;
  logic signed [XY_W:0]   xo, yo;

  function automatic logic signed [POS_W-1:0] to_mm(input logic signed [XY_W:0] v);
    logic signed [XY_W+1:0] t;
    logic signed [XY_W-15:0] r;
    t = {v[XY_W], v} + (XY_W+2)'(32768);
    r = (XY_W-14)'(t >>> 16);
    if (r > (XY_W-14)'(65535)) begin
      return POS_W'(65535);
    end else if (r < -(XY_W-14)'(65536)) begin
      return POS_W'(-65536);
    end else begin
      return r[POS_W-1:0];
    end
  endfunction

  always_comb begin
    case (stage_in.data.quad)
      2'd0: begin
        xo = {stage_in.data.x[XY_W-1], stage_in.data.x};
        yo = {stage_in.data.y[XY_W-1], stage_in.data.y};
      end
      2'd1: begin
        xo = -{stage_in.data.y[XY_W-1], stage_in.data.y};
        yo = {stage_in.data.x[XY_W-1], stage_in.data.x};
      end
      2'd2: begin
        xo = -{stage_in.data.x[XY_W-1], stage_in.data.x};
        yo = -{stage_in.data.y[XY_W-1], stage_in.data.y};
      end
      default: begin
        xo = {stage_in.data.y[XY_W-1], stage_in.data.y};
        yo = -{stage_in.data.x[XY_W-1], stage_in.data.x};
      end
    endcase
    x_nxt = stage_in.data.ok ? to_mm(xo) : '0;
    y_nxt = stage_in.data.ok ? to_mm(yo) : '0;
  end

  assign blocked = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!blocked) begin
      out_valid_r <= stage_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      res_r <= stage_in.data.ok;
      eos_r <= stage_in.data.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_pos       = x_r;
  assign out_y_pos       = y_r;
  assign out_valid_res   = res_r;
  assign out_end_of_scan = eos_r;

endmodule

// ===== hdl/laser_scan_polar_to_cartesian.sv =====
// laser_scan_polar_to_cartesian: top level, front stage, row of cordic cells, output stage
// depends on lsp2c_pkg, lsp2c_front, lsp2c_cell, lsp2c_back
// One beam transfer is taken every cycle while in_stall is low, and each passes through
// a front stage for the gate, angle and seed multiply, one cell per cordic stage, and an
// output register for quadrant rotation and rounding. Every stage holds its own valid
// bit, so empty stages fill while the output is stalled and input is stalled only when
// the whole row is full.
`timescale 1ns / 1ps

module laser_scan_polar_to_cartesian (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [lsp2c_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsp2c_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [lsp2c_pkg::RANGE_W-1:0]        in_range,
  input  logic [lsp2c_pkg::BEAM_W-1:0]         in_beam_index,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lsp2c_pkg::POS_W-1:0]   out_x_pos,
  output logic signed [lsp2c_pkg::POS_W-1:0]   out_y_pos,
  output logic                                 out_valid_res,
  output logic                                 out_end_of_scan
);
  import lsp2c_pkg::*;

  stage_t chain [NUM_CELLS+1];
  logic   blk   [NUM_CELLS+2];

  lsp2c_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_range      (in_range),
    .in_beam_index (in_beam_index),
    .in_last       (in_last),
    .down_blocked  (blk[1]),
    .blocked       (blk[0]),
    .stage_out     (chain[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    lsp2c_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .stage_idx    (IDX_W'(k)),
      .atan         (ATAN_TURN32[k]),
      .stage_in     (chain[k]),
      .down_blocked (blk[k+2]),
      .blocked      (blk[k+1]),
      .stage_out    (chain[k+1])
    );
  end

  lsp2c_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .stage_in        (chain[NUM_CELLS]),
    .blocked         (blk[NUM_CELLS+1]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_valid_res   (out_valid_res),
    .out_end_of_scan (out_end_of_scan)
  );

  assign in_stall = blk[0];

endmodule

// ===== hdl/lsp2c_checker.sv =====
// lsp2c_checker: port-level assertions for laser_scan_polar_to_cartesian
// depends on lsp2c_pkg, bound to the top level below
`timescale 1ns / 1ps

module lsp2c_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [lsp2c_pkg::POS_W-1:0]   out_x_pos,
  input logic signed [lsp2c_pkg::POS_W-1:0]   out_y_pos,
  input logic                                 out_valid_res,
  input logic                                 out_end_of_scan
);
  import lsp2c_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_pos) && $stable(out_y_pos) &&
      $stable(out_valid_res) && $stable(out_end_of_scan))
    else $error("stalled result changed");

  // stalled beam stays offered
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled beam withdrawn");

  // rejected samples carry zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_x_pos == '0 && out_y_pos == '0)
    else $error("rejected sample with nonzero coordinates");

  // input backpressure only comes from a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind laser_scan_polar_to_cartesian lsp2c_checker u_lsp2c_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_x_pos       (out_x_pos),
  .out_y_pos       (out_y_pos),
  .out_valid_res   (out_valid_res),
  .out_end_of_scan (out_end_of_scan)
);
